// ----- rtl/core/clcd_pkg.sv -----
// Shared types, codes and tables for the character-LCD nibble sequencer.
package clcd_pkg;

	// Request modes
	localparam logic [2:0] MODE_CMD       = 3'd0;
	localparam logic [2:0] MODE_DATA      = 3'd1;
	localparam logic [2:0] MODE_CURSOR    = 3'd2;
	localparam logic [2:0] MODE_BACKLIGHT = 3'd3;
	localparam logic [2:0] MODE_CLEAR     = 3'd4;
	localparam logic [2:0] MODE_HOME      = 3'd5;
	localparam logic [2:0] MODE_INIT      = 3'd6;

	// Configuration register indexes
	localparam int unsigned REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_DEV_ADDR  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_COL_COUNT = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_ROW_COUNT = 2'd2;
	localparam int unsigned REG_DATA_W = 7;

	// Reset values of the configuration registers
	localparam logic [6:0] DEV_ADDR_RST  = 7'd39;
	localparam logic [5:0] COL_COUNT_RST = 6'd16;
	localparam logic [2:0] ROW_COUNT_RST = 3'd2;

	// LCD command bytes
	localparam logic [7:0] CMD_CLEAR_DISP = 8'h01;
	localparam logic [7:0] LCD_HOME     = 8'h02;
	localparam logic [7:0] LCD_SET_DDRAM = 8'h80;

	// Init sequence shape
	localparam logic [3:0] INIT_LAST_NIB = 4'd11;
	localparam logic [5:0] POWER_UP_MS   = 6'd50;
	localparam logic [2:0] CLR_HOME_MS   = 3'd2;

	// Job kinds handed from the front to the back
	localparam logic [1:0] KIND_BYTE      = 2'd0;
	localparam logic [1:0] KIND_BACKLIGHT = 2'd1;
	localparam logic [1:0] KIND_INIT      = 2'd2;

	// Request queue depth
	localparam int unsigned QUEUE_DEPTH = 2;
	localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;       // byte to send for KIND_BYTE
		logic       rs;         // register select
		logic       bl;         // backlight bit for every written byte
		logic       extra_wait; // add clear/home settle time after last write
	} job_t;

	typedef struct packed {
		logic push;
		job_t job;
	} q_push_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} q_head_t;

	// DDRAM row start addresses
	function automatic logic [7:0] row_base(input logic [1:0] r);
		logic [7:0] b;
		unique case (r)
			2'd0: b = 8'h00;
			2'd1: b = 8'h40;
			2'd2: b = 8'h14;
			default: b = 8'h54;
		endcase
		return b;
	endfunction

	// Nibbles of the init sequence: 3,3,3,2 then 0x28, 0x0C, 0x01, 0x06
	function automatic logic [3:0] init_nibble(input logic [3:0] idx);
		logic [3:0] n;
		unique case (idx)
			4'd0, 4'd1, 4'd2: n = 4'h3;
			4'd3, 4'd4:       n = 4'h2;
			4'd5:             n = 4'h8;
			4'd6:             n = 4'h0;
			4'd7:             n = 4'hC;
			4'd8:             n = 4'h0;
			4'd9:             n = 4'h1;
			4'd10:            n = 4'h0;
			4'd11:            n = 4'h6;
			default:          n = 4'h0;
		endcase
		return n;
	endfunction

	// Extra ms after the final write of an init nibble
	function automatic logic [2:0] init_extra(input logic [3:0] idx);
		logic [2:0] e;
		unique case (idx)
			4'd0, 4'd1: e = 3'd5;
			4'd2:       e = 3'd1;
			4'd9:       e = CLR_HOME_MS; // low nibble of the clear command
			default:    e = 3'd0;
		endcase
		return e;
	endfunction

endpackage

// ----- rtl/core/clcd_front.sv -----
// Front end: accepts requests, tracks backlight, builds jobs for the queue.
module clcd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [2:0]          mode,
	input  logic [7:0]          value,
	input  logic [7:0]          column,
	input  logic [7:0]          row,
	input  logic                backlight_on,
	input  logic [5:0]          column_count,
	input  logic [2:0]          row_count,
	input  logic                q_full,
	output clcd_pkg::q_push_t   q_in
);
	import clcd_pkg::*;

	logic       backlight_q;
	logic       accept;
	logic [2:0] max_row;
	logic [5:0] max_col;
	logic [1:0] row_clamped;
	logic [7:0] col_clamped;
	logic [7:0] cursor_addr;
	job_t       job;
	logic       known;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Cursor clamp and DDRAM address
	always_comb begin
		max_row = (row_count == 3'd0) ? 3'd0 : row_count - 3'd1;
		if (max_row > 3'd3) begin
			max_row = 3'd3;
		end
		max_col = (column_count == 6'd0) ? 6'd0 : column_count - 6'd1;
		row_clamped = (row > {5'd0, max_row}) ? max_row[1:0] : row[1:0];
		col_clamped = (column > {2'd0, max_col}) ? {2'd0, max_col} : column;
		cursor_addr = LCD_SET_DDRAM | (col_clamped + row_base(row_clamped));
	end

	// Classify the request
	always_comb begin
		job.kind       = KIND_BYTE;
		job.data       = value;
		job.rs         = 1'b0;
		job.bl         = backlight_q;
		job.extra_wait = 1'b0;
		known          = 1'b1;
		unique case (mode)
			MODE_CMD: begin
			end
			MODE_DATA: begin
				job.rs = 1'b1;
			end
			MODE_CURSOR: begin
				job.data = cursor_addr;
			end
			MODE_BACKLIGHT: begin
				job.kind = KIND_BACKLIGHT;
				job.bl   = backlight_on;
			end
			MODE_CLEAR: begin
				job.data       = CMD_CLEAR_DISP;
				job.extra_wait = 1'b1;
			end
			MODE_HOME: begin
				job.data       = LCD_HOME;
				job.extra_wait = 1'b1;
			end
			MODE_INIT: begin
				job.kind = KIND_INIT;
				job.bl   = 1'b1;
			end
			default: begin
				known = 1'b0; // undefined mode is dropped
			end
		endcase
	end

	assign q_in.push = accept && known;
	assign q_in.job  = job;

	// Backlight state follows accepted requests in order
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			backlight_q <= 1'b1;
		end else if (accept && known) begin
			backlight_q <= job.bl;
		end
	end

endmodule

// ----- rtl/core/clcd_queue.sv -----
// Small job queue between the front end and the sequencer.
module clcd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  clcd_pkg::q_push_t q_in,
	input  logic              pop,
	output logic              full,
	output clcd_pkg::q_head_t head
);
	import clcd_pkg::*;

	job_t              entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full       = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];

	// Entry storage
	always_ff @(posedge clk) begin
		if (q_in.push) begin
			entry_q[wr_ptr_q] <= q_in.job;
		end
	end

	// Pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_in.push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (q_in.push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !q_in.push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid) else $error("queue popped while empty");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_in.push |-> (!full || pop)) else $error("queue pushed while full");

endmodule

// ----- rtl/core/clcd_back.sv -----
// Back end: walks each job into expander bytes, one result per cycle while a job is active and m_tready takes results.
module clcd_back (
	input  logic              clk,
	input  logic              arst_n,
	input  clcd_pkg::q_head_t head,
	output logic              pop,
	input  logic [6:0]        device_address,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        bus_write_address,
	output logic              send,
	output logic [7:0]        expander_byte,
	output logic [5:0]        wait_ms,
	output logic              last
);
	import clcd_pkg::*;

	job_t       job_q;
	logic       active_q;
	logic       pre_q;     // power-up delay still to emit
	logic [3:0] nib_q;
	logic [1:0] ph_q;      // 0 plain, 1 enable high, 2 enable low
	logic       out_valid_q;
	logic       send_q;
	logic [7:0] byte_q;
	logic [5:0] wait_q;
	logic       last_q;

	logic       can_adv;
	logic       emit;
	logic [3:0] cur_nib;
	logic [2:0] extra;
	logic       r_send;
	logic [7:0] r_byte;
	logic [5:0] r_wait;
	logic       r_last;

	assign can_adv = !out_valid_q || m_tready;
	assign emit    = active_q && can_adv;
	assign pop     = !active_q && head.valid;

	// Result for the current step
	always_comb begin
		if (job_q.kind == KIND_INIT) begin
			cur_nib = init_nibble(nib_q);
			extra   = init_extra(nib_q);
		end else begin
			cur_nib = nib_q[0] ? job_q.data[3:0] : job_q.data[7:4];
			extra   = (job_q.extra_wait && nib_q[0]) ? CLR_HOME_MS : 3'd0;
		end

		r_send = 1'b1;
		r_byte = {cur_nib, job_q.bl, (ph_q == 2'd1), 1'b0, job_q.rs};
		unique case (ph_q)
			2'd0:    r_wait = 6'd0;
			2'd1:    r_wait = 6'd1;
			default: r_wait = 6'd1 + {3'd0, extra};
		endcase
		r_last = 1'b0;

		priority if (job_q.kind == KIND_BACKLIGHT) begin
			r_byte = {4'd0, job_q.bl, 3'd0};
			r_wait = 6'd0;
			r_last = 1'b1;
		end else if (pre_q) begin
			r_send = 1'b0;
			r_byte = 8'd0;
			r_wait = POWER_UP_MS;
		end else if (job_q.kind == KIND_INIT) begin
			r_last = (nib_q == INIT_LAST_NIB) && (ph_q == 2'd2);
		end else begin
			r_last = nib_q[0] && (ph_q == 2'd2);
		end
	end

	// Job load
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head.job;
		end
	end

	// Step counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			pre_q    <= 1'b0;
			nib_q    <= '0;
			ph_q     <= '0;
		end else if (pop) begin
			active_q <= 1'b1;
			pre_q    <= (head.job.kind == KIND_INIT);
			nib_q    <= '0;
			ph_q     <= '0;
		end else if (emit) begin
			if (r_last) begin
				active_q <= 1'b0;
			end
			if (pre_q) begin
				pre_q <= 1'b0;
			end else if (ph_q == 2'd2) begin
				ph_q  <= 2'd0;
				nib_q <= nib_q + 4'd1;
			end else begin
				ph_q <= ph_q + 2'd1;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (can_adv) begin
			out_valid_q <= active_q;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			send_q <= r_send;
			byte_q <= r_byte;
			wait_q <= r_wait;
			last_q <= r_last;
		end
	end

	assign m_tvalid          = out_valid_q;
	assign bus_write_address = {device_address, 1'b0};
	assign send              = send_q;
	assign expander_byte     = byte_q;
	assign wait_ms           = wait_q;
	assign last              = last_q;

	a_phase_range: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (ph_q != 2'd3)) else $error("nibble phase out of range");
	a_byte_two_nibbles: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && job_q.kind == KIND_BYTE) |-> (nib_q <= 4'd1 && !pre_q))
		else $error("byte job beyond its two nibbles");
	a_init_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && job_q.kind == KIND_INIT) |-> (nib_q <= INIT_LAST_NIB))
		else $error("init job beyond its last nibble");

endmodule

// ----- rtl/core/char_lcd_nibble_sequencer_unit.sv -----
// Top level of the character-LCD nibble sequencer.
//
// Turns LCD requests (command, data, set cursor, backlight, clear, home, init)
// into expander writes for an HD44780 in 4-bit mode behind an I2C port
// expander, each result carrying the address, the byte and the wait in ms that
// follows it. Requests enter a two-entry queue and are accepted whenever it has
// room, also while results are still waiting downstream. The sequencer emits
// one result per cycle while a job is active and m_tready takes results: a
// byte request gives 6 results, backlight 1 result, init 37 results, and each
// job is first loaded from the queue before its results, so the sustained rate is set by the
// sequencer and by how fast m_tready takes results. Mode 7 is accepted and
// dropped. Configuration writes are meant for an idle block.
module char_lcd_nibble_sequencer_unit (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // value, column, row, backlight_on
	input  logic [2:0]                     s_tuser,  // mode
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [23:0]                    m_tdata,  // bus_write_address, expander_byte, wait_ms
	output logic                           m_tuser,  // send
	output logic                           m_tlast,
	input  logic                           wr_en,
	input  logic [clcd_pkg::REG_IDX_W-1:0] wr_index,
	input  logic [clcd_pkg::REG_DATA_W-1:0] wr_data
);
	import clcd_pkg::*;

	logic [6:0] device_address_q;
	logic [5:0] column_count_q;
	logic [2:0] row_count_q;

	q_push_t    q_in;
	q_head_t    q_head;
	logic       q_full;
	logic       q_pop;

	logic [7:0] bus_write_address;
	logic [7:0] expander_byte;
	logic [5:0] wait_ms;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= DEV_ADDR_RST;
			column_count_q   <= COL_COUNT_RST;
			row_count_q      <= ROW_COUNT_RST;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_DEV_ADDR:  device_address_q <= wr_data[6:0];
				REG_COL_COUNT: column_count_q   <= wr_data[5:0];
				REG_ROW_COUNT: row_count_q      <= wr_data[2:0];
				default: begin
				end
			endcase
		end
	end

	clcd_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.mode         (s_tuser),
		.value        (s_tdata[7:0]),
		.column       (s_tdata[15:8]),
		.row          (s_tdata[23:16]),
		.backlight_on (s_tdata[24]),
		.column_count (column_count_q),
		.row_count    (row_count_q),
		.q_full       (q_full),
		.q_in         (q_in)
	);

	clcd_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_in   (q_in),
		.pop    (q_pop),
		.full   (q_full),
		.head   (q_head)
	);

	clcd_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.head              (q_head),
		.pop               (q_pop),
		.device_address    (device_address_q),
		.m_tvalid          (m_tvalid),
		.m_tready          (m_tready),
		.bus_write_address (bus_write_address),
		.send              (m_tuser),
		.expander_byte     (expander_byte),
		.wait_ms           (wait_ms),
		.last              (m_tlast)
	);

	assign m_tdata = {2'b00, wait_ms, expander_byte, bus_write_address};

endmodule

// ----- test/tb_char_lcd_nibble_sequencer_unit.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the character-LCD nibble sequencer: random and directed requests.
module tb_char_lcd_nibble_sequencer_unit;
	import clcd_pkg::*;

	localparam logic [2:0] MODE_UNDEF = 3'd7;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 2'd3;
	localparam int unsigned CYCLE_LIMIT = 1_000_000;
	localparam int unsigned HOLD_CYCLES = 300;
	localparam int unsigned DRAIN_CYCLES = 50;
	localparam int unsigned PHASE_REQS = 52;
	localparam int unsigned PHASE_COUNT = 8;
	localparam int unsigned MAX_REPORTS = 20;

	// Expander byte bits
	localparam logic [7:0] BIT_RS = 8'h01;
	localparam logic [7:0] BIT_EN = 8'h04;
	localparam logic [7:0] BIT_BL = 8'h08;

	// Init sequence bytes and waits
	localparam logic [7:0] WAKE_NIBBLE     = 8'h30;
	localparam logic [7:0] FOUR_BIT_NIBBLE = 8'h20;
	localparam logic [7:0] LCD_FUNC_SET    = 8'h28;
	localparam logic [7:0] CMD_DISP_CTRL   = 8'h0C;
	localparam logic [7:0] CMD_ENTRY_SET   = 8'h06;
	localparam logic [5:0] WAKE_SETTLE_MS  = 6'd5;
	localparam logic [5:0] WAKE_LAST_MS    = 6'd1;

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] value;
		logic [7:0] column;
		logic [7:0] row;
		logic       bl_on;
	} lcd_req_t;

	typedef struct packed {
		logic [7:0] addr;
		logic       send;
		logic [7:0] xbyte;
		logic [5:0] wait_ms;
		logic       last;
	} lcd_write_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [31:0]           s_tdata = '0;  // value, column, row, backlight_on
	logic [2:0]            s_tuser = '0;  // mode
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;       // bus_write_address, expander_byte, wait_ms
	logic                  m_tuser;       // send
	logic                  m_tlast;
	logic                  wr_en = 1'b0;
	logic [REG_IDX_W-1:0]  wr_index = '0;
	logic [REG_DATA_W-1:0] wr_data = '0;

	// Predictor state
	logic [6:0] cfg_dev_addr = DEV_ADDR_RST;
	logic [5:0] cfg_col_count = COL_COUNT_RST;
	logic [2:0] cfg_row_count = ROW_COUNT_RST;
	logic       bl_state = 1'b1;

	lcd_req_t   lcd_req_q[$];
	lcd_write_t expander_write_q[$];
	lcd_req_t   cur_req;
	lcd_write_t got_write;
	lcd_write_t exp_write;

	int unsigned reqs_issued = 0;
	int unsigned reqs_accepted = 0;
	int unsigned writes_checked = 0;
	int unsigned errors = 0;
	int unsigned cycle_count = 0;
	int unsigned settings_used = 1;
	int unsigned src_idle_max = 8;
	int unsigned rcv_idle_max = 8;
	int unsigned src_gap = 0;
	int unsigned rcv_gap = 0;
	int unsigned hold_left = 0;
	int unsigned holds_asked = 0;
	int unsigned holds_granted = 0;

	char_lcd_nibble_sequencer_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------- predictor ----------------

	function automatic logic [7:0] row_start(logic [1:0] r);
		case (r)
			2'd0: return 8'h00;
			2'd1: return 8'h40;
			2'd2: return 8'h14;
			default: return 8'h54;
		endcase
	endfunction

	function automatic void queue_write(logic snd, logic [7:0] xb, logic [5:0] ms);
		lcd_write_t w;
		w.addr = {cfg_dev_addr, 1'b0};
		w.send = snd;
		w.xbyte = xb;
		w.wait_ms = ms;
		w.last = 1'b0;
		expander_write_q.push_back(w);
	endfunction

	// extra settle time after the most recent write
	function automatic void add_settle(logic [5:0] ms);
		lcd_write_t w;
		w = expander_write_q.pop_back();
		w.wait_ms = w.wait_ms + ms;
		expander_write_q.push_back(w);
	endfunction

	// plain, enable high, enable low
	function automatic void queue_nibble(logic [7:0] bits);
		logic [7:0] b;
		b = (bits & 8'hF1) | (bl_state ? BIT_BL : 8'h00);
		queue_write(1'b1, b, 6'd0);
		queue_write(1'b1, b | BIT_EN, 6'd1);
		queue_write(1'b1, b & ~BIT_EN, 6'd1);
	endfunction

	function automatic void queue_byte(logic [7:0] v, logic [7:0] rs);
		queue_nibble((v & 8'hF0) | rs);
		queue_nibble({v[3:0], 4'h0} | rs);
	endfunction

	function automatic void predict_expander_writes(lcd_req_t r);
		int unsigned n0;
		logic [2:0] max_row;
		logic [5:0] max_col;
		logic [7:0] row_c;
		logic [7:0] col_c;
		logic [7:0] ddram;
		lcd_write_t w;
		n0 = expander_write_q.size();
		case (r.mode)
			MODE_CMD: queue_byte(r.value, 8'h00);
			MODE_DATA: queue_byte(r.value, BIT_RS);
			MODE_CURSOR: begin
				// zero counts act as one, rows past the table stop at the last entry
				max_row = (cfg_row_count == 3'd0) ? 3'd0 : cfg_row_count - 3'd1;
				if (max_row > 3'd3)
					max_row = 3'd3;
				max_col = (cfg_col_count == 6'd0) ? 6'd0 : cfg_col_count - 6'd1;
				row_c = (r.row > {5'd0, max_row}) ? {5'd0, max_row} : r.row;
				col_c = (r.column > {2'd0, max_col}) ? {2'd0, max_col} : r.column;
				ddram = col_c + row_start(row_c[1:0]);
				queue_byte(LCD_SET_DDRAM | ddram, 8'h00);
			end
			MODE_BACKLIGHT: begin
				bl_state = r.bl_on;
				queue_write(1'b1, bl_state ? BIT_BL : 8'h00, 6'd0);
			end
			MODE_CLEAR: begin
				queue_byte(CMD_CLEAR_DISP, 8'h00);
				add_settle(6'(CLR_HOME_MS));
			end
			MODE_HOME: begin
				queue_byte(LCD_HOME, 8'h00);
				add_settle(6'(CLR_HOME_MS));
			end
			MODE_INIT: begin
				bl_state = 1'b1;
				queue_write(1'b0, 8'h00, POWER_UP_MS);
				queue_nibble(WAKE_NIBBLE);
				add_settle(WAKE_SETTLE_MS);
				queue_nibble(WAKE_NIBBLE);
				add_settle(WAKE_SETTLE_MS);
				queue_nibble(WAKE_NIBBLE);
				add_settle(WAKE_LAST_MS);
				queue_nibble(FOUR_BIT_NIBBLE);
				queue_byte(LCD_FUNC_SET, 8'h00);
				queue_byte(CMD_DISP_CTRL, 8'h00);
				queue_byte(CMD_CLEAR_DISP, 8'h00);
				add_settle(6'(CLR_HOME_MS));
				queue_byte(CMD_ENTRY_SET, 8'h00);
			end
			default: ;
		endcase
		if (expander_write_q.size() > n0) begin
			w = expander_write_q.pop_back();
			w.last = 1'b1;
			expander_write_q.push_back(w);
		end
	endfunction

	// ---------------- request driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			s_tuser <= '0;
			src_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_expander_writes(cur_req);
				reqs_accepted++;
				src_gap = $urandom_range(0, src_idle_max);
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (lcd_req_q.size() > 0) begin
					cur_req = lcd_req_q.pop_front();
					s_tvalid <= 1'b1;
					s_tuser <= cur_req.mode;
					s_tdata <= {7'd0, cur_req.bl_on, cur_req.row, cur_req.column, cur_req.value};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ---------------- result monitor ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			rcv_gap = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_write.addr = m_tdata[7:0];
				got_write.send = m_tuser;
				got_write.xbyte = m_tdata[15:8];
				got_write.wait_ms = m_tdata[21:16];
				got_write.last = m_tlast;
				if (expander_write_q.size() == 0) begin
					errors++;
					if (errors <= MAX_REPORTS)
						$display("%0t: unexpected write addr=%h send=%b byte=%h wait=%0d last=%b",
							$time, got_write.addr, got_write.send, got_write.xbyte,
							got_write.wait_ms, got_write.last);
				end else begin
					exp_write = expander_write_q.pop_front();
					writes_checked++;
					if (got_write !== exp_write) begin
						errors++;
						if (errors <= MAX_REPORTS) begin
							$display("%0t: mismatch expected addr=%h send=%b byte=%h wait=%0d last=%b",
								$time, exp_write.addr, exp_write.send, exp_write.xbyte,
								exp_write.wait_ms, exp_write.last);
							$display("%0t:          actual   addr=%h send=%b byte=%h wait=%0d last=%b",
								$time, got_write.addr, got_write.send, got_write.xbyte,
								got_write.wait_ms, got_write.last);
						end
					end
				end
				rcv_gap = $urandom_range(0, rcv_idle_max);
			end
			// long hold-off requested by the stimulus
			if (holds_granted != holds_asked) begin
				holds_granted = holds_asked;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (rcv_gap > 0) begin
				rcv_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// ---------------- watchdog ----------------

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d writes still expected",
				cycle_count, expander_write_q.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	// ---------------- stimulus ----------------

	task automatic send_req(logic [2:0] mode, logic [7:0] value, logic [7:0] column,
		logic [7:0] row, logic bl_on);
		lcd_req_t r;
		r.mode = mode;
		r.value = value;
		r.column = column;
		r.row = row;
		r.bl_on = bl_on;
		lcd_req_q.push_back(r);
		reqs_issued++;
	endtask

	task automatic write_reg(logic [REG_IDX_W-1:0] idx, logic [REG_DATA_W-1:0] d);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= d;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_DEV_ADDR: cfg_dev_addr = d;
			REG_COL_COUNT: cfg_col_count = d[5:0];
			REG_ROW_COUNT: cfg_row_count = d[2:0];
			default: ;
		endcase
	endtask

	// all requests taken, all writes seen, then let a dropped request settle
	task automatic wait_idle();
		while (reqs_accepted != reqs_issued || expander_write_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		int unsigned n;
		int unsigned pick;
		logic [2:0] mode;
		logic [6:0] dev;
		logic [6:0] cols;
		logic [6:0] rows;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: every mode, field extremes, backlight handling
		send_req(MODE_INIT, 8'h00, 8'h00, 8'h00, 1'b0);
		send_req(MODE_CMD, 8'h00, 8'h00, 8'h00, 1'b0);
		send_req(MODE_CMD, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_req(MODE_DATA, 8'hA5, 8'h00, 8'h00, 1'b0);
		send_req(MODE_DATA, 8'h5A, 8'h00, 8'h00, 1'b0);
		send_req(MODE_CURSOR, 8'h00, 8'h00, 8'h00, 1'b0);
		send_req(MODE_CURSOR, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_req(MODE_CURSOR, 8'h00, 8'd15, 8'd1, 1'b0);
		send_req(MODE_CURSOR, 8'h00, 8'd3, 8'd200, 1'b0);
		send_req(MODE_BACKLIGHT, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_req(MODE_DATA, 8'h41, 8'h00, 8'h00, 1'b1);
		send_req(MODE_CLEAR, 8'h00, 8'h00, 8'h00, 1'b0);
		send_req(MODE_HOME, 8'h00, 8'h00, 8'h00, 1'b0);
		// init must turn the backlight back on
		send_req(MODE_INIT, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_req(MODE_BACKLIGHT, 8'h00, 8'h00, 8'h00, 1'b1);
		send_req(MODE_UNDEF, 8'hFF, 8'hFF, 8'hFF, 1'b1);
		send_req(MODE_DATA, 8'hFF, 8'h00, 8'h00, 1'b0);
		wait_idle();

		// random phases, one register setting each
		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin dev = 7'd0;   cols = 7'd1;  rows = 7'd1; end
				1: begin dev = 7'd127; cols = 7'd63; rows = 7'd7; end
				2: begin dev = 7'd39;  cols = 7'd0;  rows = 7'd0; end
				3: begin dev = 7'd85;  cols = 7'd40; rows = 7'd4; end
				4: begin dev = 7'd42;  cols = 7'd20; rows = 7'd5; end
				default: begin
					dev = 7'($urandom_range(0, 127));
					cols = 7'($urandom_range(0, 127));
					rows = 7'($urandom_range(0, 127));
				end
			endcase
			write_reg(REG_DEV_ADDR, dev);
			write_reg(REG_COL_COUNT, cols);
			write_reg(REG_ROW_COUNT, rows);
			if (p == 3)
				write_reg(REG_UNUSED, 7'($urandom_range(0, 127)));
			settings_used++;

			src_idle_max = (p == 1 || p == 4 || p == 5) ? 0 : 8;
			rcv_idle_max = (p == 2 || p == 5) ? 0 : 8;

			n = 0;
			while (n < PHASE_REQS) begin
				pick = $urandom_range(0, 99);
				if (pick < 4)
					mode = MODE_INIT;
				else if (pick < 8)
					mode = MODE_UNDEF;
				else
					mode = 3'($urandom_range(0, 5));
				send_req(mode, 8'($urandom),
					$urandom_range(0, 1) ? 8'($urandom_range(0, 63)) : 8'($urandom),
					$urandom_range(0, 1) ? 8'($urandom_range(0, 7)) : 8'($urandom),
					1'($urandom));
				if (mode != MODE_UNDEF)
					n++;
			end
			// stall the output while requests keep coming so the input backs up
			if (p == 4)
				holds_asked++;
			wait_idle();
		end

		$display("Checked %0d expander writes from %0d requests over %0d register settings,",
			writes_checked, reqs_accepted, settings_used);
		$display("including zero and oversized row/column counts and a long output stall.");
		if (errors == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("%0d errors", errors);
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/clcd_pkg.sv
rtl/core/clcd_front.sv
rtl/core/clcd_queue.sv
rtl/core/clcd_back.sv
rtl/core/char_lcd_nibble_sequencer_unit.sv
test/tb_char_lcd_nibble_sequencer_unit.sv
